[rtl/core/cmnf_pkg.sv]
// ----------------------------------------------------------------------------
// cmnf_pkg
// Shared types, constants and helpers of the caseless match finder navigator.
// ----------------------------------------------------------------------------
package cmnf_pkg;

    localparam int ROW_WIDTH   = 80;
    localparam int MATCH_DEPTH = 64;
    localparam int QUERY_MAX   = 8;
    localparam int ROW_LIMIT   = 1024;

    localparam int ADDR_W  = $clog2(MATCH_DEPTH) > 0 ? $clog2(MATCH_DEPTH) : 1;
    localparam int CAP_W   = $clog2(MATCH_DEPTH + 1);

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_CELL   = 3'd1;
    localparam logic [2:0] OP_FWD    = 3'd2;
    localparam logic [2:0] OP_BWD    = 3'd3;
    localparam logic [2:0] OP_PROBE  = 3'd4;
    localparam logic [2:0] OP_CANCEL = 3'd5;

    localparam logic CFG_QLEN  = 1'b0;
    localparam logic CFG_QTEXT = 1'b1;

    typedef enum logic [2:0] {
        K_START, K_CELL, K_FWD, K_BWD, K_PROBE, K_CANCEL, K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [9:0]  row;
        logic [6:0]  col;
    } t_cmd;

    typedef struct packed {
        logic               hit;
        logic signed [10:0] row;
        logic signed [7:0]  col;
        logic signed [6:0]  idx;
        logic [15:0]        count;
    } t_res;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

[rtl/core/cmnf_front.sv]
// ----------------------------------------------------------------------------
// cmnf_front
// Accepts input transactions, decodes the opcode and queues up to two commands.
// ----------------------------------------------------------------------------
module cmnf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,
    input  logic [2:0]        s_axis_tuser,
    output logic              o_cmd_valid,
    output cmnf_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import cmnf_pkg::*;

    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cmd        w_cmd;
    logic        w_push;

    always_comb begin
        case (s_axis_tuser)
            OP_START:  w_cmd.kind = K_START;
            OP_CELL:   w_cmd.kind = K_CELL;
            OP_FWD:    w_cmd.kind = K_FWD;
            OP_BWD:    w_cmd.kind = K_BWD;
            OP_PROBE:  w_cmd.kind = K_PROBE;
            OP_CANCEL: w_cmd.kind = K_CANCEL;
            default:   w_cmd.kind = K_NOP;
        endcase
        w_cmd.ch  = s_axis_tdata[7:0];
        w_cmd.row = s_axis_tdata[17:8];
        w_cmd.col = s_axis_tdata[24:18];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign o_cmd         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_cmd_pop) |=> r_cnt == 2'd2) else $error("full queue lost entry");
`endif

endmodule

[rtl/core/cmnf_back.sv]
// ----------------------------------------------------------------------------
// cmnf_back
// Executes commands: window compare, match store, find and probe sequencer.
// ----------------------------------------------------------------------------
module cmnf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  cmnf_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic [3:0]        i_qlen,
    input  logic [63:0]       i_qtext,
    output logic              o_res_valid,
    output cmnf_pkg::t_res    o_res,
    input  logic              i_res_ready
);
    import cmnf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_OUT} t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic               r_fix, n_fix;
    logic               r_hit, n_hit;
    logic [7:0]         r_win [8];
    logic [7:0]         n_win [8];
    logic [6:0]         r_fill, n_fill;
    logic [15:0]        r_total, n_total;
    logic signed [10:0] r_cur_row, n_cur_row;
    logic signed [7:0]  r_cur_col, n_cur_col;
    logic signed [6:0]  r_cur_idx, n_cur_idx;
    logic               r_active, n_active;

    logic [16:0]        r_mem [MATCH_DEPTH];
    logic [16:0]        r_rdata;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [16:0]        w_wdata;

    logic [3:0]         w_q;
    logic [CAP_W-1:0]   w_cap;
    logic [ADDR_W-1:0]  w_last;
    logic [7:0]         w_shift [8];
    logic [6:0]         w_fill;
    logic               w_same, w_cell_ok, w_cell_hit;
    logic [2:0]         w_wi;
    logic [9:0]         w_erow;
    logic [6:0]         w_ecol;
    logic               w_fwd, w_cond, w_end, w_in;

    assign w_q    = (i_qlen > 4'(QUERY_MAX)) ? 4'(QUERY_MAX) : i_qlen;
    assign w_cap  = (r_total >= 16'(MATCH_DEPTH)) ? CAP_W'(MATCH_DEPTH) : CAP_W'(r_total);
    assign w_last = ADDR_W'(w_cap - CAP_W'(1));
    assign w_erow = r_rdata[16:7];
    assign w_ecol = r_rdata[6:0];
    assign w_fwd  = (i_cmd.kind == K_FWD);

    // Window compare for a page cell: newest character sits in slot zero.
    always_comb begin
        w_shift[0] = i_cmd.ch;
        for (int i = 1; i < 8; i++) begin
            w_shift[i] = r_win[i-1];
        end
        w_fill = (i_cmd.col == 7'd0) ? 7'd1 :
                 ((r_fill == 7'd127) ? 7'd127 : r_fill + 7'd1);
        w_same = 1'b1;
        w_wi   = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < w_q) begin
                w_wi = 3'(w_q - 4'd1 - 4'(i));
                if (fold_case(w_shift[w_wi]) != fold_case(i_qtext[8*i +: 8])) begin
                    w_same = 1'b0;
                end
            end
        end
        w_cell_ok  = r_active && ({1'b0, i_cmd.row} < 11'(ROW_LIMIT))
                     && (i_cmd.col < 7'(ROW_WIDTH));
        w_cell_hit = w_cell_ok && (w_q != 4'd0) && (w_fill >= {3'b0, w_q})
                     && (({1'b0, i_cmd.col} + 8'd1) >= {4'b0, w_q}) && w_same;
    end

    always_comb begin
        w_in = (i_cmd.row == w_erow) && (i_cmd.col >= w_ecol)
               && ({1'b0, i_cmd.col} < ({1'b0, w_ecol} + {4'b0, w_q}));
        if (w_fwd) begin
            w_cond = r_cur_idx[6] || (w_erow > r_cur_row[9:0])
                     || (w_erow == r_cur_row[9:0] && w_ecol > r_cur_col[6:0]);
            w_end  = (r_ptr == w_last);
        end else begin
            w_cond = r_cur_idx[6] || (w_erow < r_cur_row[9:0])
                     || (w_erow == r_cur_row[9:0] && w_ecol < r_cur_col[6:0]);
            w_end  = (r_ptr == '0);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_fix     = r_fix;
        n_hit     = r_hit;
        n_win     = r_win;
        n_fill    = r_fill;
        n_total   = r_total;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_cur_idx = r_cur_idx;
        n_active  = r_active;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        w_we    = 1'b0;
        w_waddr = ADDR_W'(r_total);
        w_wdata = {i_cmd.row, 7'(i_cmd.col + 7'd1 - {3'b0, w_q})};
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_FWD, K_BWD: begin
                            n_fix = 1'b0;
                            if (w_q == 4'd0) begin
                                n_state = S_OUT;
                            end else if (w_cap == '0) begin
                                n_cur_row = '1;
                                n_cur_col = '1;
                                n_cur_idx = '1;
                                n_state   = S_OUT;
                            end else begin
                                n_ptr   = w_fwd ? '0 : w_last;
                                n_state = S_RD;
                            end
                        end
                        K_PROBE: begin
                            n_hit = 1'b0;
                            if (!r_active || w_q == 4'd0 || w_cap == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            if (i_res_ready) begin
                                o_cmd_pop   = 1'b1;
                                o_res_valid = 1'b1;
                                if (i_cmd.kind == K_START || i_cmd.kind == K_CANCEL) begin
                                    n_active  = (i_cmd.kind == K_START);
                                    n_fill    = '0;
                                    n_total   = '0;
                                    n_cur_row = '1;
                                    n_cur_col = '1;
                                    n_cur_idx = '1;
                                    if (i_cmd.kind == K_START) begin
                                        for (int i = 0; i < 8; i++) begin
                                            n_win[i] = '0;
                                        end
                                    end
                                end else if (i_cmd.kind == K_CELL && w_cell_ok) begin
                                    n_win  = w_shift;
                                    n_fill = w_fill;
                                    if (w_cell_hit) begin
                                        w_we = (r_total < 16'(MATCH_DEPTH));
                                        if (r_total != 16'hFFFF) begin
                                            n_total = r_total + 16'd1;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_cmd.kind == K_PROBE) begin
                    if (w_in) begin
                        n_hit   = 1'b1;
                        n_state = S_OUT;
                    end else if (r_ptr == w_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_ptr   = r_ptr + ADDR_W'(1);
                        n_state = S_RD;
                    end
                end else if (r_fix || w_cond) begin
                    n_cur_row = {1'b0, w_erow};
                    n_cur_col = {1'b0, w_ecol};
                    n_cur_idx = 7'(r_ptr);
                    n_state   = S_OUT;
                end else if (w_end) begin
                    n_ptr   = w_fwd ? '0 : w_last;
                    n_fix   = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_ptr   = w_fwd ? r_ptr + ADDR_W'(1) : r_ptr - ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.hit   = (i_cmd.kind == K_PROBE) ? n_hit : !n_cur_idx[6];
        o_res.row   = n_cur_row;
        o_res.col   = n_cur_col;
        o_res.idx   = n_cur_idx;
        o_res.count = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_fix <= n_fix;
        r_hit <= n_hit;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_total   <= '0;
            r_cur_row <= '1;
            r_cur_col <= '1;
            r_cur_idx <= '1;
            r_active  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_total   <= n_total;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_cur_idx <= n_cur_idx;
            r_active  <= n_active;
        end
    end

`ifndef ASSERT_OFF
    a_ptr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (CAP_W'(r_ptr) < w_cap))
        else $error("store read beyond filled entries");
    a_cur_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_idx[6] == r_cur_row[10]) && (r_cur_idx[6] == r_cur_col[7]))
        else $error("current match fields disagree");
    a_pop_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (o_res_valid && i_res_ready && i_cmd_valid))
        else $error("command retired without a result");
    a_no_write_while_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE)) else $error("store write during lookup");
`endif

endmodule

[rtl/core/caseless_match_finder_navigator_unit.sv]
// ----------------------------------------------------------------------------
// caseless_match_finder_navigator_unit
// Case-insensitive substring search over a streamed page, with match
// navigation and cell highlighting probes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents (low bit first)
//  s_axis    in         tdata: cell_char, cell_row, cell_col; tuser: opcode
//  m_axis    out        tdata: hit, current row, current column, match_index,
//                       match_count
//  i_cfg_*   in         register write: index 0 query_length, 1 query_text
//
// Start, cancel, page cell and unused opcodes retire in the executor's idle
// state. Find and probe walk the match store with a single registered read
// port, each entry passing through a read and a check state: a probe visits
// at most min(matches,64) entries, a find at most min(matches,64)+1 when it
// wraps around. Reset is synchronous and active low; the match store needs no
// clearing pass because only entries written since the last start are ever read.
// A two-entry command queue lets the input keep accepting while the executor
// works, and an output register holds the last result while the sink stalls.
// ----------------------------------------------------------------------------
module caseless_match_finder_navigator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // cell_char, cell_row, cell_col, zero fill
    input  logic [2:0]   s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // hit, row, col, index, count, zero fill
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    import cmnf_pkg::*;

    logic [3:0]   r_qlen;
    logic [63:0]  r_qtext;
    logic         w_cmd_valid, w_cmd_pop;
    t_cmd         w_cmd;
    logic         w_res_valid, w_res_ready;
    t_res         w_res;
    logic         r_out_valid;
    t_res         r_out;

    // Query registers; the user must write them only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen  <= '0;
            r_qtext <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QLEN:  r_qlen  <= i_cfg_data[3:0];
                CFG_QTEXT: r_qtext <= i_cfg_data;
                default:   r_qlen  <= r_qlen;
            endcase
        end
    end

    cmnf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    cmnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_qlen      (r_qlen),
        .i_qtext     (r_qtext),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // The output register takes a new result whenever it is empty or its
    // current transaction completes in the same cycle.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.count, r_out.idx, r_out.col, r_out.row, r_out.hit};

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_res_only_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_res_ready) else $error("result produced without room");
    a_out_hit_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.idx[6] == r_out.row[10]))
        else $error("result row and index disagree");
`endif

endmodule
